>>> hw/rtl/rhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhs_pkg: shared definitions for the rolling hash substring search
// Field widths, register reset values, opcodes, FSM states and the request
// and response types of the remainder unit.
// ---------------------------------------------------------------------------
package rhs_pkg;

    localparam int HASH_W   = 26;
    localparam int SHIFT_W  = 4;
    localparam int TEXT_W   = 32;
    localparam int OP_W     = 2;
    localparam int SYM_W    = 7;
    localparam int DIGIT_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam int WINDOW_MAX_DEF = 1024;

    localparam logic [HASH_W-1:0]  MOD_RESET   = 26'd10000019;
    localparam logic [HASH_W-1:0]  MOD_MIN     = 26'd2;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd8;
    localparam logic [SYM_W-1:0]   SYM_BASE    = 7'd97;
    localparam logic [TEXT_W-1:0]  TEXT_SAT    = 32'hFFFF_FFFF;

    // remainder unit: operand is left aligned, two bits retired per cycle
    localparam int REM_OPND_W = 36;
    localparam int REM_PAIR_W = 5;
    localparam logic [REM_PAIR_W-1:0] PAIRS_MUL  = 5'd16; // 32-bit product field
    localparam logic [REM_PAIR_W-1:0] PAIRS_SUB  = 5'd14; // 28-bit difference field
    localparam logic [REM_PAIR_W-1:0] PAIRS_ROLL = 5'd18; // 36-bit shift-add field
    localparam logic [REM_PAIR_W-1:0] PAIRS_RFAC = 5'd17; // 34-bit shift field

    typedef enum logic [OP_W-1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS = 1'b0,
        CFG_SHIFT   = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_W_MUL,
        S_W_SUB,
        S_ROLL,
        S_W_ROLL,
        S_PAT,
        S_W_PAT,
        S_RFAC,
        S_W_RFAC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [REM_PAIR_W-1:0] pairs;
        logic [REM_OPND_W-1:0] operand;
    } t_rem_req;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] value;
    } t_rem_rsp;

endpackage
`default_nettype wire

>>> hw/rtl/rhs_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhs_in_if: request channel
// Valid/ready channel carrying one opcode and one symbol per request.
// ---------------------------------------------------------------------------
interface rhs_in_if
    import rhs_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rhs_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhs_out_if: result channel
// Valid/ready channel carrying one search result per request.
// ---------------------------------------------------------------------------
interface rhs_out_if
    import rhs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              match_found;
    logic [TEXT_W-1:0] window_start;
    logic              pattern_overflow;

    modport source (output valid, output match_found, output window_start,
                    output pattern_overflow, input ready);
    modport sink   (input valid, input match_found, input window_start,
                    input pattern_overflow, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rhs_modred.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rhs_modred: iterative remainder unit
// Restoring remainder of a left-aligned operand by the modulus, two bits
// per cycle; done pulses as the final remainder is registered.
// ---------------------------------------------------------------------------
module rhs_modred
    import rhs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_rem_req          i_req,
    input  wire logic [HASH_W-1:0] i_modulus,
    output t_rem_rsp               o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [REM_PAIR_W-1:0] r_cnt;
    logic [REM_OPND_W-1:0] r_opnd;
    logic [HASH_W-1:0]     r_rem;
    logic [HASH_W-1:0]     w_step1;
    logic [HASH_W-1:0]     w_step2;

    // one restoring step: remainder stays below the modulus
    function automatic logic [HASH_W-1:0] rem_step(input logic [HASH_W-1:0] r,
                                                   input logic              b,
                                                   input logic [HASH_W-1:0] m);
        logic [HASH_W:0] t;
        t = {r, b};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[HASH_W-1:0];
    endfunction

    assign w_step1 = rem_step(r_rem, r_opnd[REM_OPND_W-1], i_modulus);
    assign w_step2 = rem_step(w_step1, r_opnd[REM_OPND_W-2], i_modulus);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.pairs;
            end else if (r_busy) begin
                r_cnt <= r_cnt - REM_PAIR_W'(1);
                if (r_cnt == REM_PAIR_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_opnd <= i_req.operand;
        end else if (r_busy) begin
            r_rem  <= w_step2;
            r_opnd <= {r_opnd[REM_OPND_W-3:0], 2'b00};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_rem;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a preceding iteration");

    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < i_modulus))
        else $error("remainder not below modulus");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/rolling_hash_substring_search_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Restart, unused opcode or dropped pattern symbol go straight to the result; a text
// symbol rolls the window hash, first removing the oldest digit once the window is full;
// a pattern symbol updates the pattern hash and, after the first, the removal factor. One
// request at a time; the rate is set by the shared two-bits-per-cycle remainder unit.
// Synchronous active-low reset clears the hash state (removal factor to one) and restores both registers;
// the window store needs no clearing, since only entries written since a clear are read.
// ---------------------------------------------------------------------------
// rolling_hash_substring_search_top: Rabin-Karp substring search
// Pattern symbols build the pattern hash and removal factor; text symbols
// roll through a circular window store and report hash matches.
// ---------------------------------------------------------------------------
module rolling_hash_substring_search_top
    import rhs_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    rhs_in_if.sink                    i_req,
    rhs_out_if.source                 o_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [HASH_W-1:0]    i_cfg_data
);

    localparam int WP_W   = $clog2(WINDOW_MAX);
    localparam int PLEN_W = $clog2(WINDOW_MAX + 1);
    localparam int AS_W   = PLEN_W + 1;

    t_state              r_state;
    t_state              n_state;

    logic [HASH_W-1:0]   r_mod;
    logic [SHIFT_W-1:0]  r_shift;
    logic [HASH_W-1:0]   w_mod;
    logic [SHIFT_W-1:0]  w_sh;

    logic [HASH_W-1:0]   r_ph;
    logic [HASH_W-1:0]   r_wh;
    logic [HASH_W-1:0]   r_rf;
    logic [PLEN_W-1:0]   r_plen;
    logic [TEXT_W-1:0]   r_tcnt;
    logic [WP_W-1:0]     r_wp;
    logic [DIGIT_W-1:0]  r_digit;
    logic                r_rf_upd;
    logic [DIGIT_W-1:0]  r_old;

    logic                r_res_match;
    logic [TEXT_W-1:0]   r_res_start;
    logic                r_res_ovf;

    logic                r_out_valid;
    logic                r_out_match;
    logic [TEXT_W-1:0]   r_out_start;
    logic                r_out_ovf;

    logic                w_accept;
    logic                w_out_load;
    logic                w_remove;
    logic                w_full;
    logic [SYM_W-1:0]    w_sym_off;
    logic [DIGIT_W-1:0]  w_digit;
    logic [WP_W-1:0]     w_rd_addr;
    logic [AS_W-1:0]     w_wrap_sum;
    logic [PLEN_W-1:0]   w_fwd_diff;
    logic [WP_W-1:0]     w_wp_inc;

    logic [30:0]         w_prod;
    logic [HASH_W:0]     w_sub;
    logic [33:0]         w_wh_shl;
    logic [33:0]         w_ph_shl;
    logic [33:0]         w_rf_shl;
    logic [34:0]         w_roll;
    logic [34:0]         w_pat;

    t_rem_req            rem_req;
    t_rem_rsp            rem_rsp;

    logic [DIGIT_W-1:0]  r_store [WINDOW_MAX];

    // effective modulus and shift
    assign w_mod = (r_mod < MOD_MIN) ? MOD_MIN : r_mod;
    assign w_sh  = (r_shift < SHIFT_MIN) ? SHIFT_MIN :
                   (r_shift > SHIFT_MAX) ? SHIFT_MAX : r_shift;

    assign w_accept  = i_req.valid && i_req.ready;
    assign w_sym_off = i_req.symbol - SYM_BASE;
    assign w_digit   = w_sym_off[DIGIT_W-1:0];

    assign w_remove = (r_plen != '0) && (r_tcnt >= TEXT_W'(r_plen));
    assign w_full   = w_remove;

    // oldest window entry sits pattern_length places behind the write pointer
    assign w_wrap_sum = AS_W'(r_wp) + AS_W'(WINDOW_MAX) - AS_W'(r_plen);
    assign w_fwd_diff = PLEN_W'(r_wp) - r_plen;
    assign w_rd_addr  = (PLEN_W'(r_wp) >= r_plen) ? w_fwd_diff[WP_W-1:0]
                                                  : w_wrap_sum[WP_W-1:0];
    assign w_wp_inc   = (r_wp == WP_W'(WINDOW_MAX - 1)) ? '0 : r_wp + WP_W'(1);

    // window store: read-first, so the oldest entry is seen before its overwrite
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_req.opcode == OP_TEXT)) begin
            r_store[r_wp] <= w_digit;
        end
        r_old <= r_store[w_rd_addr];
    end

    assign w_prod   = 31'(r_rf) * 31'(r_old);
    assign w_sub    = (HASH_W+1)'(r_wh) + (HASH_W+1)'(w_mod) - (HASH_W+1)'(rem_rsp.value);
    assign w_wh_shl = 34'(r_wh) << w_sh;
    assign w_ph_shl = 34'(r_ph) << w_sh;
    assign w_rf_shl = 34'(r_rf) << w_sh;
    assign w_roll   = 35'(w_wh_shl) + 35'(r_digit);
    assign w_pat    = 35'(w_ph_shl) + 35'(r_digit);

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        rem_req     = '0;
        case (r_state)
            S_IDLE: begin
                // no request taken while in reset
                i_req.ready = i_rst_n;
                if (i_req.valid) begin
                    case (i_req.opcode)
                        OP_TEXT:    n_state = w_remove ? S_MUL : S_ROLL;
                        OP_PATTERN: n_state = (r_plen < PLEN_W'(WINDOW_MAX)) ? S_PAT
                                                                              : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_MUL: begin
                rem_req.start   = 1'b1;
                rem_req.pairs   = PAIRS_MUL;
                rem_req.operand = {1'b0, w_prod, 4'b0000};
                n_state         = S_W_MUL;
            end
            S_W_MUL: begin
                if (rem_rsp.done) begin
                    rem_req.start   = 1'b1;
                    rem_req.pairs   = PAIRS_SUB;
                    rem_req.operand = {1'b0, w_sub, 8'h00};
                    n_state         = S_W_SUB;
                end
            end
            S_W_SUB: begin
                if (rem_rsp.done) begin
                    n_state = S_ROLL;
                end
            end
            S_ROLL: begin
                rem_req.start   = 1'b1;
                rem_req.pairs   = PAIRS_ROLL;
                rem_req.operand = {1'b0, w_roll};
                n_state         = S_W_ROLL;
            end
            S_W_ROLL: begin
                if (rem_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_PAT: begin
                rem_req.start   = 1'b1;
                rem_req.pairs   = PAIRS_ROLL;
                rem_req.operand = {1'b0, w_pat};
                n_state         = S_W_PAT;
            end
            S_W_PAT: begin
                if (rem_rsp.done) begin
                    n_state = r_rf_upd ? S_RFAC : S_DONE;
                end
            end
            S_RFAC: begin
                rem_req.start   = 1'b1;
                rem_req.pairs   = PAIRS_RFAC;
                rem_req.operand = {w_rf_shl, 2'b00};
                n_state         = S_W_RFAC;
            end
            S_W_RFAC: begin
                if (rem_rsp.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    rhs_modred u_modred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rem_req),
        .i_modulus (w_mod),
        .o_rsp     (rem_rsp)
    );

    // hash state, counters and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= MOD_RESET;
            r_shift <= SHIFT_RESET;
            r_ph    <= '0;
            r_wh    <= '0;
            r_rf    <= HASH_W'(1);
            r_plen  <= '0;
            r_tcnt  <= '0;
            r_wp    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODULUS: r_mod   <= i_cfg_data;
                    CFG_SHIFT:   r_shift <= i_cfg_data[SHIFT_W-1:0];
                    default:     ;
                endcase
            end
            if (w_accept) begin
                case (i_req.opcode)
                    OP_PATTERN: begin
                        r_wh   <= '0;
                        r_tcnt <= '0;
                        r_wp   <= '0;
                        if (r_plen < PLEN_W'(WINDOW_MAX)) begin
                            r_plen <= r_plen + PLEN_W'(1);
                        end
                    end
                    OP_TEXT: begin
                        r_wp <= w_wp_inc;
                        if (r_tcnt != TEXT_SAT) begin
                            r_tcnt <= r_tcnt + TEXT_W'(1);
                        end
                    end
                    OP_RESTART: begin
                        r_ph   <= '0;
                        r_wh   <= '0;
                        r_rf   <= HASH_W'(1);
                        r_plen <= '0;
                        r_tcnt <= '0;
                        r_wp   <= '0;
                    end
                    default: ;
                endcase
            end
            if (rem_rsp.done) begin
                case (r_state)
                    S_W_SUB:  r_wh <= rem_rsp.value;
                    S_W_ROLL: r_wh <= rem_rsp.value;
                    S_W_PAT:  r_ph <= rem_rsp.value;
                    S_W_RFAC: r_rf <= rem_rsp.value;
                    default:  ;
                endcase
            end
        end
    end

    // per-request scratch and pending result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_digit     <= w_digit;
            r_rf_upd    <= (r_plen != '0);
            r_res_match <= 1'b0;
            r_res_start <= '0;
            r_res_ovf   <= (i_req.opcode == OP_PATTERN) &&
                           (r_plen >= PLEN_W'(WINDOW_MAX));
        end
        // counter already advanced at accept
        if ((r_state == S_W_ROLL) && rem_rsp.done && w_full) begin
            r_res_match <= (rem_rsp.value == r_ph);
            r_res_start <= r_tcnt - TEXT_W'(r_plen);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_match <= r_res_match;
            r_out_start <= r_res_start;
            r_out_ovf   <= r_res_ovf;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.match_found      = r_out_match;
    assign o_res.window_start     = r_out_start;
    assign o_res.pattern_overflow = r_out_ovf;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_rsp.done |-> (r_state == S_W_MUL || r_state == S_W_SUB ||
                          r_state == S_W_ROLL || r_state == S_W_PAT ||
                          r_state == S_W_RFAC))
        else $error("remainder result arrived outside a wait state");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp < WP_W'(WINDOW_MAX - 1)) || (r_wp == WP_W'(WINDOW_MAX - 1)))
        else $error("write pointer beyond window store");

    a_plen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAT) |-> (r_plen != '0) && (r_plen <= PLEN_W'(WINDOW_MAX)))
        else $error("pattern length out of range while hashing");
`endif

endmodule
`default_nettype wire
